/* rtl/core/cti_pkg.sv */
// Shared constants, codes and beat types of the complex table interpolator.
package cti_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRACTION_BITS = 16;

    localparam int POS_W       = 32;
    localparam int INT_W       = POS_W - FRACTION_BITS;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 11;
    localparam int ENTRY_IDX_W = 10;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int ENTRY_W     = 2 * SAMPLE_WIDTH;
    localparam int PROD_W      = SAMPLE_WIDTH + FRACTION_BITS + 2;
    localparam int NUM_CELLS   = INT_W;

    localparam logic [LEN_W-1:0]         LEN_RESET  = LEN_W'(1024);
    localparam logic [FRACTION_BITS-1:0] FRAC_HALF  =
        FRACTION_BITS'(1) << (FRACTION_BITS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = CFG_IDX_W'(1);

    localparam logic [MODE_W-1:0] MODE_FLOOR      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEAREST    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LINEAR     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LINEAR_ALT = 2'd3;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                             op;
        logic signed [POS_W-1:0]         position;
        logic [ENTRY_IDX_W-1:0]          entry_index;
        logic signed [SAMPLE_WIDTH-1:0]  entry_real;
        logic signed [SAMPLE_WIDTH-1:0]  entry_imag;
        logic                            last_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0]  result_real;
        logic signed [SAMPLE_WIDTH-1:0]  result_imag;
        logic                            last_out;
    } t_out_beat;

    typedef struct packed {
        logic                       valid;
        t_op                        op;
        logic                       last;
        logic                       neg;
        logic [FRACTION_BITS-1:0]   frac;
        logic [INT_W-1:0]           dvd;
        logic [LEN_W-1:0]           rem;
        logic [ENTRY_IDX_W-1:0]     widx;
        logic [ENTRY_W-1:0]         wdata;
    } t_cell_beat;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic [FRACTION_BITS-1:0]   frac;
        logic [ENTRY_W-1:0]         elo;
        logic [ENTRY_W-1:0]         ehi;
    } t_rd_beat;

    typedef struct packed {
        logic      valid;
        t_out_beat data;
    } t_res_beat;

endpackage

/* rtl/core/cti_in_if.sv */
// Input channel of the complex table interpolator: valid, ready and one input beat.
interface cti_in_if import cti_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/cti_out_if.sv */
// Output channel of the complex table interpolator: valid, ready and one result beat.
interface cti_out_if import cti_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/cti_mod_cell.sv */
// One cell of the modulo chain: shifts in one position bit and reduces the remainder.
module cti_mod_cell import cti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [LEN_W-1:0] i_len,
    input  t_cell_beat       i_beat,
    output t_cell_beat       o_beat
);

    t_cell_beat       r_stage;
    t_cell_beat       n_stage;
    logic [LEN_W:0]   w_trial;
    logic [LEN_W:0]   w_diff;

    always_comb begin
        w_trial = {i_beat.rem, i_beat.dvd[INT_W-1]};
        w_diff  = w_trial - {1'b0, i_len};
        n_stage = i_beat;
        n_stage.dvd = i_beat.dvd << 1;
        if (w_trial >= {1'b0, i_len}) begin
            n_stage.rem = w_diff[LEN_W-1:0];
        end else begin
            n_stage.rem = w_trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.op    <= n_stage.op;
            r_stage.last  <= n_stage.last;
            r_stage.neg   <= n_stage.neg;
            r_stage.frac  <= n_stage.frac;
            r_stage.dvd   <= n_stage.dvd;
            r_stage.rem   <= n_stage.rem;
            r_stage.widx  <= n_stage.widx;
            r_stage.wdata <= n_stage.wdata;
        end
    end

    assign o_beat = r_stage;

endmodule

/* rtl/core/cti_table.sv */
// Index folding, table write and dual read of the low and high neighbor entries.
module cti_table import cti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [LEN_W-1:0] i_len,
    input  t_cell_beat       i_beat,
    output t_rd_beat         o_beat
);

    logic [ENTRY_W-1:0]       r_mem [TABLE_DEPTH];

    logic                     r_a_valid;
    logic                     r_a_wen;
    logic                     r_a_last;
    logic [FRACTION_BITS-1:0] r_a_frac;
    logic [IDX_W-1:0]         r_a_lo;
    logic [IDX_W-1:0]         r_a_hi;
    logic [IDX_W-1:0]         r_a_widx;
    logic [ENTRY_W-1:0]       r_a_wdata;

    logic                     r_b_valid;
    logic                     r_b_last;
    logic [FRACTION_BITS-1:0] r_b_frac;
    logic [ENTRY_W-1:0]       r_b_elo;
    logic [ENTRY_W-1:0]       r_b_ehi;

    logic [LEN_W-1:0]         w_fold;
    logic [LEN_W:0]           w_inc;
    logic [IDX_W-1:0]         w_hi;
    logic                     w_lookup;
    logic                     w_wen;

    always_comb begin
        if (i_beat.neg && (i_beat.rem != '0)) begin
            w_fold = i_len - i_beat.rem;
        end else begin
            w_fold = i_beat.rem;
        end
        w_inc = {1'b0, w_fold} + (LEN_W + 1)'(1);
        if (w_inc >= {1'b0, i_len}) begin
            w_hi = '0;
        end else begin
            w_hi = w_inc[IDX_W-1:0];
        end
        w_lookup = i_beat.valid && (i_beat.op == OP_LOOKUP);
        w_wen    = i_beat.valid && (i_beat.op == OP_WRITE)
                   && ({22'd0, i_beat.widx} < TABLE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_wen   <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= w_lookup;
            r_a_wen   <= w_wen;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_last  <= i_beat.last;
            r_a_frac  <= i_beat.frac;
            r_a_lo    <= w_fold[IDX_W-1:0];
            r_a_hi    <= w_hi;
            r_a_widx  <= IDX_W'(i_beat.widx);
            r_a_wdata <= i_beat.wdata;
            r_b_last  <= r_a_last;
            r_b_frac  <= r_a_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_a_wen) begin
                r_mem[r_a_widx] <= r_a_wdata;
            end
            r_b_elo <= r_mem[r_a_lo];
            r_b_ehi <= r_mem[r_a_hi];
        end
    end

    always_comb begin
        o_beat.valid = r_b_valid;
        o_beat.last  = r_b_last;
        o_beat.frac  = r_b_frac;
        o_beat.elo   = r_b_elo;
        o_beat.ehi   = r_b_ehi;
    end

endmodule

/* rtl/core/cti_interp.sv */
// Mode selection, fraction multiply and final add of the real and imaginary parts.
module cti_interp import cti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [MODE_W-1:0] i_mode,
    input  t_rd_beat          i_beat,
    output t_res_beat         o_res
);

    logic                           r_c_valid;
    logic                           r_c_last;
    logic signed [SAMPLE_WIDTH-1:0] r_c_base_re;
    logic signed [SAMPLE_WIDTH-1:0] r_c_base_im;
    logic signed [PROD_W-1:0]       r_c_prod_re;
    logic signed [PROD_W-1:0]       r_c_prod_im;

    logic signed [SAMPLE_WIDTH-1:0] w_lo_re;
    logic signed [SAMPLE_WIDTH-1:0] w_lo_im;
    logic signed [SAMPLE_WIDTH-1:0] w_hi_re;
    logic signed [SAMPLE_WIDTH-1:0] w_hi_im;
    logic signed [SAMPLE_WIDTH:0]   w_diff_re;
    logic signed [SAMPLE_WIDTH:0]   w_diff_im;
    logic signed [FRACTION_BITS:0]  w_frac;
    logic signed [SAMPLE_WIDTH-1:0] n_base_re;
    logic signed [SAMPLE_WIDTH-1:0] n_base_im;
    logic signed [PROD_W-1:0]       n_prod_re;
    logic signed [PROD_W-1:0]       n_prod_im;
    logic signed [PROD_W-1:0]       w_sum_re;
    logic signed [PROD_W-1:0]       w_sum_im;

    always_comb begin
        w_lo_re   = i_beat.elo[SAMPLE_WIDTH-1:0];
        w_lo_im   = i_beat.elo[ENTRY_W-1:SAMPLE_WIDTH];
        w_hi_re   = i_beat.ehi[SAMPLE_WIDTH-1:0];
        w_hi_im   = i_beat.ehi[ENTRY_W-1:SAMPLE_WIDTH];
        w_diff_re = (SAMPLE_WIDTH + 1)'(w_hi_re) - (SAMPLE_WIDTH + 1)'(w_lo_re);
        w_diff_im = (SAMPLE_WIDTH + 1)'(w_hi_im) - (SAMPLE_WIDTH + 1)'(w_lo_im);
        w_frac    = $signed({1'b0, i_beat.frac});
        n_base_re = w_lo_re;
        n_base_im = w_lo_im;
        n_prod_re = '0;
        n_prod_im = '0;
        unique case (i_mode)
            MODE_FLOOR: begin
            end
            MODE_NEAREST: begin
                if (i_beat.frac > FRAC_HALF) begin
                    n_base_re = w_hi_re;
                    n_base_im = w_hi_im;
                end
            end
            MODE_LINEAR, MODE_LINEAR_ALT: begin
                n_prod_re = w_frac * w_diff_re;
                n_prod_im = w_frac * w_diff_im;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_last    <= i_beat.last;
            r_c_base_re <= n_base_re;
            r_c_base_im <= n_base_im;
            r_c_prod_re <= n_prod_re;
            r_c_prod_im <= n_prod_im;
        end
    end

    always_comb begin
        w_sum_re = PROD_W'(r_c_base_re) + (r_c_prod_re >>> FRACTION_BITS);
        w_sum_im = PROD_W'(r_c_base_im) + (r_c_prod_im >>> FRACTION_BITS);
        o_res.valid            = r_c_valid;
        o_res.data.result_real = w_sum_re[SAMPLE_WIDTH-1:0];
        o_res.data.result_imag = w_sum_im[SAMPLE_WIDTH-1:0];
        o_res.data.last_out    = r_c_last;
    end

endmodule

/* rtl/core/complex_table_interpolator.sv */
// Top level of the complex table interpolator: modulo cell chain, table and interpolation.
//
// Input beats on i_in either write one complex table entry (op write) or look up a
// signed Q16.16 position (op lookup). Each lookup gives one beat on o_out with the
// floor, nearest or linearly interpolated complex sample and its last flag; writes
// give no beat. Writes and lookups take effect in the order they were accepted.
// Table length and mode are set through the write port i_cfg_we / i_cfg_index /
// i_cfg_data. The user must write them only while no beat is in flight; the block
// itself does not enforce this. One beat is accepted every cycle while the skid
// register is empty. The edge that accepts a lookup loads the first of 16 modulo
// cells (one integer bit of the position per cell); after the last cell one stage
// folds the index, one reads the dual-read table, one does the fraction multiply
// and the next loads the output register, which drives o_out.
// Reset clears all valid flags and sets length 1024 and linear mode; table entries
// are undefined until written and there is no clearing pass.
// When o_out is stalled, the output register holds and a skid register takes one
// more result; while the skid register is full the whole pipeline holds and
// i_in.ready is low. The ready of i_in never depends on o_out.ready in the same cycle.
module complex_table_interpolator import cti_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cti_in_if.sink                i_in,
    cti_out_if.source             o_out
);

    logic [LEN_W-1:0]  r_len;
    logic [MODE_W-1:0] r_mode;
    logic [LEN_W-1:0]  w_len_clamp;

    t_cell_beat        w_chain [NUM_CELLS+1];
    logic [INT_W-1:0]  w_ip;
    logic              w_en;
    t_rd_beat          w_rd;
    t_res_beat         w_res;
    logic              w_take;

    logic              r_out_v;
    t_out_beat         r_out;
    logic              r_skid_v;
    t_out_beat         r_skid;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_len_clamp = LEN_W'(1);
        end else if (i_cfg_data > CFG_DATA_W'(TABLE_DEPTH)) begin
            w_len_clamp = LEN_W'(TABLE_DEPTH);
        end else begin
            w_len_clamp = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RESET;
            r_mode <= MODE_LINEAR;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TABLE_LENGTH) begin
                r_len <= w_len_clamp;
            end else if (i_cfg_index == CFG_MODE) begin
                r_mode <= i_cfg_data[MODE_W-1:0];
            end
        end
    end

    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    always_comb begin
        w_ip = i_in.data.position[POS_W-1:FRACTION_BITS];
        w_chain[0].valid = i_in.valid && w_en;
        w_chain[0].op    = i_in.data.op;
        w_chain[0].last  = i_in.data.last_in;
        w_chain[0].neg   = w_ip[INT_W-1];
        w_chain[0].frac  = i_in.data.position[FRACTION_BITS-1:0];
        w_chain[0].dvd   = w_ip[INT_W-1] ? (~w_ip + INT_W'(1)) : w_ip;
        w_chain[0].rem   = '0;
        w_chain[0].widx  = i_in.data.entry_index;
        w_chain[0].wdata = {i_in.data.entry_imag, i_in.data.entry_real};
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cti_mod_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_len   (r_len),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    cti_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_len   (r_len),
        .i_beat  (w_chain[NUM_CELLS]),
        .o_beat  (w_rd)
    );

    cti_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_mode  (r_mode),
        .i_beat  (w_rd),
        .o_res   (w_res)
    );

    assign w_take = w_res.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_take;
            end
        end else if (w_take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (w_take) begin
                r_out <= w_res.data;
            end
        end else if (w_take) begin
            r_skid <= w_res.data;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

endmodule

/* sim/tb_complex_table_interpolator.sv */
// Testbench for the complex table interpolator: directed and random beats checked against a predictor.
module tb_complex_table_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import cti_pkg::*;

    class sample_scoreboard;
        logic [ENTRY_W-1:0] table_copy [TABLE_DEPTH];
        bit                 written [TABLE_DEPTH];
        logic [LEN_W-1:0]   length_reg;
        logic [MODE_W-1:0]  mode_reg;
        t_out_beat          expected_samples [$];
        int                 errors;
        int                 lookups;
        int                 writes;

        function new();
            length_reg = LEN_RESET;
            mode_reg   = MODE_LINEAR;
            errors     = 0;
            lookups    = 0;
            writes     = 0;
            foreach (written[k]) written[k] = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_TABLE_LENGTH) begin
                length_reg = value[LEN_W-1:0];
            end else if (index == CFG_MODE) begin
                mode_reg = value[MODE_W-1:0];
            end
        endfunction

        function int span();
            if (length_reg == 0) return 1;
            if (length_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return int'(length_reg);
        endfunction

        function int next_slot(int lo);
            return (lo + 1 >= span()) ? 0 : lo + 1;
        endfunction

        function int blend(int a, int b, int frac);
            longint prod;
            prod = longint'(frac) * longint'(b - a);
            return a + int'(prod >>> FRACTION_BITS);
        endfunction

        function t_out_beat interpolate(t_in_beat b);
            int                 len;
            int                 ip;
            int                 lo;
            int                 frac;
            logic [ENTRY_W-1:0] elo;
            logic [ENTRY_W-1:0] ehi;
            logic [ENTRY_W-1:0] pick;
            t_out_beat          r;
            len  = span();
            ip   = int'($signed(b.position[POS_W-1:FRACTION_BITS]));
            lo   = ip % len;
            if (lo < 0) lo += len;
            frac = int'(b.position[FRACTION_BITS-1:0]);
            elo  = table_copy[lo];
            ehi  = table_copy[next_slot(lo)];
            r.last_out = b.last_in;
            if (mode_reg == MODE_FLOOR || mode_reg == MODE_NEAREST) begin
                pick = (mode_reg == MODE_NEAREST && frac > int'(FRAC_HALF)) ? ehi : elo;
                r.result_real = pick[SAMPLE_WIDTH-1:0];
                r.result_imag = pick[ENTRY_W-1:SAMPLE_WIDTH];
            end else begin
                r.result_real = SAMPLE_WIDTH'(blend(int'($signed(elo[SAMPLE_WIDTH-1:0])),
                    int'($signed(ehi[SAMPLE_WIDTH-1:0])), frac));
                r.result_imag = SAMPLE_WIDTH'(blend(int'($signed(elo[ENTRY_W-1:SAMPLE_WIDTH])),
                    int'($signed(ehi[ENTRY_W-1:SAMPLE_WIDTH])), frac));
            end
            return r;
        endfunction

        function void note_beat(t_in_beat b);
            if (b.op == OP_WRITE) begin
                table_copy[b.entry_index] = {b.entry_imag, b.entry_real};
                written[b.entry_index]    = 1'b1;
                writes++;
            end else begin
                expected_samples.push_back(interpolate(b));
                lookups++;
            end
        endfunction

        function void flag_field(string field, int want, int got);
            errors++;
            if (errors <= 40) begin
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with no lookup pending, real %0d imag %0d last %0b",
                         $time, got.result_real, got.result_imag, got.last_out);
                return;
            end
            want = expected_samples.pop_front();
            if (got.result_real !== want.result_real) begin
                flag_field("result_real", int'(want.result_real), int'(got.result_real));
            end
            if (got.result_imag !== want.result_imag) begin
                flag_field("result_imag", int'(want.result_imag), int'(got.result_imag));
            end
            if (got.last_out !== want.last_out) begin
                flag_field("last_out", int'(want.last_out), int'(got.last_out));
            end
        endfunction

        function int pick_lookup_slot();
            int len;
            int count;
            int nth;
            len   = span();
            count = 0;
            for (int k = 0; k < len; k++) begin
                if (written[k] && written[next_slot(k)]) count++;
            end
            if (count == 0) return -1;
            nth = $urandom_range(0, count - 1);
            for (int k = 0; k < len; k++) begin
                if (written[k] && written[next_slot(k)]) begin
                    if (nth == 0) return k;
                    nth--;
                end
            end
            return -1;
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cti_in_if  in_if ();
    cti_out_if out_if ();

    complex_table_interpolator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    sample_scoreboard board = new();
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;
    int settings_used;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400us;
        $display("FAIL complex_table_interpolator");
        $finish;
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) board.check_result(out_if.data);
            if (rx_hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_in_beat lookup_beat(logic [POS_W-1:0] pos, logic last);
        t_in_beat b;
        b.op          = OP_LOOKUP;
        b.position    = pos;
        b.entry_index = ENTRY_IDX_W'($urandom);
        b.entry_real  = SAMPLE_WIDTH'($urandom);
        b.entry_imag  = SAMPLE_WIDTH'($urandom);
        b.last_in     = last;
        return b;
    endfunction

    function automatic t_in_beat write_beat(int index, logic [SAMPLE_WIDTH-1:0] re,
                                            logic [SAMPLE_WIDTH-1:0] im);
        t_in_beat b;
        b.op          = OP_WRITE;
        b.position    = POS_W'($urandom);
        b.entry_index = ENTRY_IDX_W'(index);
        b.entry_real  = re;
        b.entry_imag  = im;
        b.last_in     = 1'($urandom);
        return b;
    endfunction

    function automatic t_in_beat random_lookup(int lo);
        int                       len;
        int                       ip;
        int                       r;
        logic [FRACTION_BITS-1:0] frac;
        len = board.span();
        ip  = int'($urandom_range(0, 65535)) - 32768;
        r   = ip % len;
        if (r < 0) r += len;
        ip = ip - r + lo;
        if (ip > 32767) ip -= len;
        if (ip < -32768) ip += len;
        case ($urandom_range(0, 7))
            0: frac = '0;
            1: frac = FRAC_HALF;
            2: frac = '1;
            3: frac = FRAC_HALF + 1'b1;
            default: frac = FRACTION_BITS'($urandom);
        endcase
        return lookup_beat({INT_W'(ip), frac}, 1'($urandom));
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
            1: return {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic int write_slot();
        int len;
        len = board.span();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, TABLE_DEPTH - 1);
            1: return $urandom_range(0, len - 1);
            default: return $urandom_range(0, (len < 64 ? len : 64) - 1);
        endcase
    endfunction

    task automatic send_beat(t_in_beat b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= b;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_beat(b);
    endtask

    task automatic quiesce();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.expected_samples.size() != 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic apply_settings(int len, logic [MODE_W-1:0] m);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TABLE_LENGTH;
        i_cfg_data  <= CFG_DATA_W'(len);
        @(posedge i_clk);
        board.set_register(CFG_TABLE_LENGTH, CFG_DATA_W'(len));
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= CFG_DATA_W'(m);
        @(posedge i_clk);
        board.set_register(CFG_MODE, CFG_DATA_W'(m));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(int count, int pause_at);
        int slot;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) begin
                in_if.valid <= 1'b0;
                do @(posedge i_clk); while (board.expected_samples.size() != 0);
            end
            slot = board.pick_lookup_slot();
            if (slot < 0 || $urandom_range(0, 99) < 30) begin
                send_beat(write_beat(write_slot(), random_sample(), random_sample()));
            end else begin
                send_beat(random_lookup(slot));
            end
        end
    endtask

    initial begin
        logic [POS_W-1:0]  probes [7];
        int                lens [9];
        logic [MODE_W-1:0] modes [9];
        probes = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_8001, 32'h7FFF_FFFF,
                   32'h0000_0000, 32'h0000_8000, 32'h0002_7FFF};
        lens   = '{1, 2, 0, 37, 2047, 1024, 1024, 5, 300};
        modes  = '{MODE_LINEAR_ALT, MODE_FLOOR, MODE_NEAREST, MODE_LINEAR, MODE_FLOOR,
                   MODE_NEAREST, MODE_LINEAR_ALT, MODE_LINEAR, MODE_NEAREST};
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 0;
        settings_used  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(write_beat(0, 16'h7FFF, 16'h8000));
        send_beat(write_beat(1, 16'h8000, 16'h7FFF));
        send_beat(write_beat(2, 16'h0000, 16'hFFFF));
        send_beat(write_beat(3, 16'hFFFF, 16'h0000));
        send_beat(write_beat(TABLE_DEPTH - 1, 16'h1234, 16'hEDCB));
        for (int k = 0; k < 7; k++) send_beat(lookup_beat(probes[k], 1'(k)));
        quiesce();
        apply_settings(TABLE_DEPTH, MODE_NEAREST);
        for (int k = 0; k < 7; k++) send_beat(lookup_beat(probes[k], 1'(k + 1)));
        quiesce();
        apply_settings(TABLE_DEPTH, MODE_FLOOR);
        for (int k = 0; k < 4; k++) send_beat(lookup_beat(probes[k], 1'(k)));
        quiesce();

        for (int p = 0; p < 9; p++) begin
            apply_settings(lens[p], modes[p]);
            if (p < 3) begin
                tx_idle_pct = 21;
                rx_idle_pct = 67;
            end else if (p < 6) begin
                tx_idle_pct = 67;
                rx_idle_pct = 21;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 6) rx_hold_cycles = 300;
            run_phase(50, (p == 7) ? 25 : -1);
            quiesce();
        end

        $display("Covered %0d lookups and %0d table writes under %0d length and mode settings,",
                 board.lookups, board.writes, settings_used);
        $display("with gaps on both sides, a long output stall and a full drain mid-stream.");
        if (board.errors == 0) begin
            $display("PASS complex_table_interpolator");
        end else begin
            $display("FAIL complex_table_interpolator");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/cti_pkg.sv
rtl/core/cti_in_if.sv
rtl/core/cti_out_if.sv
rtl/core/cti_mod_cell.sv
rtl/core/cti_table.sv
rtl/core/cti_interp.sv
rtl/core/complex_table_interpolator.sv
sim/tb_complex_table_interpolator.sv
